### hw/rtl/brr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_pkg: shared types and constants of the bounded rate renormalizer
// Beat types, fixed-point constants, register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int RATE_W      = 32;
  localparam int FRAC_BITS   = 24;
  localparam int SCALE_W     = 2 * FRAC_BITS + 1;
  localparam int DIG_W       = 16;
  localparam int NUM_DIGITS  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_RATE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_RATE = 1'b1;

  localparam logic [RATE_W-1:0] MIN_RATE_RST = 32'd17;
  localparam logic [RATE_W-1:0] MAX_RATE_RST = 32'd16777216;

  typedef struct packed {
    logic [RATE_W-1:0] rate_value;
    logic              last_value;
  } in_beat_t;

  typedef struct packed {
    logic [RATE_W-1:0] corrected_value;
    logic              last_out;
    logic              infeasible;
  } out_beat_t;

  typedef struct packed {
    logic load;
    logic vec_init;
    logic rnd_init;
    logic clamp;
    logic idx_inc;
    logic idx_clr;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic scale_wr;
    logic round_end;
    logic vec_done;
  } brr_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic free_zero;
    logic div_last;
    logic mul_last;
    logic elem_pinned;
    logic go_on;
  } brr_sts_t;

endpackage
`default_nettype wire

### hw/rtl/brr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_datapath: vector store, clamp and sum, divider and digit multiplier
// Holds the element memory, pin flags, bounds, accumulators, the restoring
// divider for the scale and the digit-serial scale multiplier.
// ----------------------------------------------------------------------------
module brr_datapath #(
  parameter int MAX_VALUES = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire [brr_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire [brr_pkg::RATE_W-1:0]           cfg_data,
  input  brr_pkg::in_beat_t                   item,
  input  brr_pkg::brr_cmd_t                   cmd,
  output brr_pkg::brr_sts_t                   sts,
  output brr_pkg::out_beat_t                  result
);
  import brr_pkg::*;

  localparam int IW     = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
  localparam int CW     = $clog2(MAX_VALUES + 1);
  localparam int SUM_W  = VALUE_BITS + CW;
  localparam int MASS_W = 34 + CW;
  localparam int PCW    = $clog2(2 * MAX_VALUES + 2);
  localparam int RCW    = $clog2(2 * MAX_VALUES + 3);
  localparam int DCW    = $clog2(SCALE_W + 1);
  localparam int MCW    = $clog2(NUM_DIGITS);
  localparam int PROD_W = VALUE_BITS + NUM_DIGITS * DIG_W;
  localparam int PP_W   = VALUE_BITS + DIG_W;
  localparam int PAD_W  = NUM_DIGITS * DIG_W - SCALE_W;

  localparam logic [VALUE_BITS-1:0] VALUE_MASK = '1;
  localparam logic [PCW-1:0]        PIN_SENT   = PCW'(2 * MAX_VALUES + 1);
  localparam logic [RCW-1:0]        ROUND_CAP  = RCW'(2 * MAX_VALUES + 2);
  localparam logic [MASS_W-1:0]     ONE_Q      = MASS_W'(64'd1 << FRAC_BITS);

  logic [VALUE_BITS-1:0] mem [MAX_VALUES];
  logic [VALUE_BITS-1:0] rdata;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;

  logic [RATE_W-1:0]     min_rate;
  logic [RATE_W-1:0]     max_rate;
  logic [VALUE_BITS-1:0] lo;
  logic [VALUE_BITS-1:0] hi;

  logic [MAX_VALUES-1:0] pin_lo;
  logic [MAX_VALUES-1:0] pin_hi;
  logic [CW-1:0]         cnt;
  logic [IW-1:0]         idx;
  logic [SUM_W-1:0]      free_sum;
  logic [MASS_W-1:0]     mass;
  logic [PCW-1:0]        pin_cnt;
  logic [PCW-1:0]        prev_pinned;
  logic [PCW-1:0]        now_pinned;
  logic [RCW-1:0]        rounds;
  logic                  not_ok;
  logic                  infeasible;

  logic [SUM_W:0]        rem;
  logic [SCALE_W-1:0]    dq;
  logic [DCW-1:0]        dcnt;
  logic [SUM_W:0]        shifted;
  logic                  qbit;

  logic [VALUE_BITS-1:0] x_mul;
  logic [PROD_W-1:0]     acc;
  logic [MCW-1:0]        mcnt;
  logic [NUM_DIGITS*DIG_W-1:0] scale_pad;
  logic [DIG_W-1:0]      digit;
  logic [PP_W-1:0]       pp;

  logic                  set_lo;
  logic                  set_hi;
  logic                  new_lo;
  logic                  new_hi;
  logic [VALUE_BITS-1:0] clamp_val;
  logic [63-FRAC_BITS:0] prod_q;
  logic                  prod_sat;
  logic [VALUE_BITS-1:0] x_new;
  logic [FRAC_BITS:0]    diff;

  // Bounds saturated to the value range
  assign lo = (64'(min_rate) > 64'(VALUE_MASK)) ? VALUE_MASK : VALUE_BITS'(min_rate);
  assign hi = (64'(max_rate) > 64'(VALUE_MASK)) ? VALUE_MASK : VALUE_BITS'(max_rate);

  assign set_lo    = (rdata <= lo);
  assign set_hi    = !set_lo && (hi <= rdata);
  assign new_lo    = pin_lo[idx] | set_lo;
  assign new_hi    = pin_hi[idx] | set_hi;
  assign clamp_val = set_lo ? lo : (set_hi ? hi : rdata);

  assign shifted = {rem[SUM_W-1:0], dq[SCALE_W-1]};
  assign qbit    = (shifted >= {1'b0, free_sum});
  assign diff    = (FRAC_BITS + 1)'(ONE_Q - mass);

  assign scale_pad = {{PAD_W{1'b0}}, dq};
  assign digit     = scale_pad[mcnt*DIG_W +: DIG_W];
  assign pp        = x_mul * digit;

  assign prod_q   = acc[63:FRAC_BITS];
  assign prod_sat = (|acc[PROD_W-1:64]) || (64'(prod_q) > 64'(VALUE_MASK));
  assign x_new    = prod_sat ? VALUE_MASK : VALUE_BITS'(prod_q);

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = clamp_val;
    if (cmd.load) begin
      we    = (cnt < CW'(MAX_VALUES));
      waddr = cnt[IW-1:0];
      wdata = VALUE_BITS'(item.rate_value);
    end else if (cmd.clamp) begin
      we = 1'b1;
    end else if (cmd.scale_wr) begin
      we    = 1'b1;
      wdata = x_new;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rate <= MIN_RATE_RST;
      max_rate <= MAX_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_RATE: min_rate <= cfg_data;
        REG_MAX_RATE: max_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_lo      <= '0;
      pin_hi      <= '0;
      cnt         <= '0;
      idx         <= '0;
      free_sum    <= '0;
      mass        <= '0;
      pin_cnt     <= '0;
      prev_pinned <= PIN_SENT;
      now_pinned  <= '0;
      rounds      <= '0;
      not_ok      <= 1'b0;
      infeasible  <= 1'b0;
      dcnt        <= '0;
      mcnt        <= '0;
    end else begin
      if (cmd.load && (cnt < CW'(MAX_VALUES))) begin
        cnt <= cnt + CW'(1);
      end
      if (cmd.vec_done) begin
        cnt <= '0;
      end
      if (cmd.vec_init) begin
        pin_lo      <= '0;
        pin_hi      <= '0;
        prev_pinned <= PIN_SENT;
        now_pinned  <= '0;
        rounds      <= '0;
        infeasible  <= 1'b0;
      end
      if (cmd.rnd_init) begin
        free_sum <= '0;
        mass     <= '0;
        pin_cnt  <= '0;
        not_ok   <= 1'b0;
        idx      <= '0;
      end
      if (cmd.idx_inc) begin
        idx <= idx + IW'(1);
      end
      if (cmd.idx_clr || cmd.div_start) begin
        idx <= '0;
      end
      if (cmd.clamp) begin
        pin_lo[idx] <= new_lo;
        pin_hi[idx] <= new_hi;
        if (!set_lo && !set_hi) begin
          free_sum <= free_sum + SUM_W'(rdata);
        end
        mass <= mass + (new_lo ? MASS_W'(lo) : '0) + (new_hi ? MASS_W'(hi) : '0);
        pin_cnt <= pin_cnt + PCW'(new_lo) + PCW'(new_hi);
      end
      if (cmd.div_start) begin
        dcnt <= DCW'(SCALE_W);
        if (mass >= ONE_Q) begin
          infeasible <= 1'b1;
        end
      end
      if (cmd.div_step) begin
        dcnt <= dcnt - DCW'(1);
      end
      if (cmd.mul_start) begin
        mcnt <= MCW'(NUM_DIGITS - 1);
      end
      if (cmd.mul_step) begin
        mcnt <= mcnt - MCW'(1);
      end
      if (cmd.scale_wr && ((x_new <= lo) || (hi <= x_new))) begin
        not_ok <= 1'b1;
      end
      if (cmd.round_end) begin
        prev_pinned <= now_pinned;
        now_pinned  <= pin_cnt;
        rounds      <= rounds + RCW'(1);
      end
    end
  end

  // Divider and multiplier payload
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem <= '0;
      dq  <= (mass >= ONE_Q) ? '0 : {diff, {FRAC_BITS{1'b0}}};
    end else if (cmd.div_step) begin
      rem <= qbit ? (shifted - {1'b0, free_sum}) : shifted;
      dq  <= {dq[SCALE_W-2:0], qbit};
    end
    if (cmd.mul_start) begin
      x_mul <= rdata;
      acc   <= '0;
    end else if (cmd.mul_step) begin
      acc <= (acc << DIG_W) + PROD_W'(pp);
    end
  end

  assign sts.idx_last    = ((CW'(idx) + CW'(1)) == cnt);
  assign sts.free_zero   = (free_sum == '0);
  assign sts.div_last    = (dcnt == DCW'(1));
  assign sts.mul_last    = (mcnt == '0);
  assign sts.elem_pinned = pin_lo[idx] | pin_hi[idx];
  assign sts.go_on       = (prev_pinned != now_pinned) && not_ok && (rounds < ROUND_CAP);

  assign result.corrected_value = (64'(rdata) > 64'hFFFF_FFFF) ? '1 : RATE_W'(rdata);
  assign result.last_out        = sts.idx_last;
  assign result.infeasible      = infeasible;

endmodule
`default_nettype wire

### hw/rtl/brr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brr_ctrl: sequencer of the bounded rate renormalizer
// Steps load, clamp passes, division, scale passes and the output sweep.
// ----------------------------------------------------------------------------
module brr_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                item_valid,
  input  wire                item_last,
  output logic               item_stall,
  output logic               result_valid,
  input  wire                result_stall,
  input  brr_pkg::brr_sts_t  sts,
  output brr_pkg::brr_cmd_t  cmd
);
  import brr_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_CL_RD  = 4'd1;
  localparam logic [3:0] S_CL_EX  = 4'd2;
  localparam logic [3:0] S_DIV_GO = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SC_RD  = 4'd5;
  localparam logic [3:0] S_SC_CHK = 4'd6;
  localparam logic [3:0] S_SC_MUL = 4'd7;
  localparam logic [3:0] S_SC_WR  = 4'd8;
  localparam logic [3:0] S_RND    = 4'd9;
  localparam logic [3:0] S_CHK    = 4'd10;
  localparam logic [3:0] S_EM_RD  = 4'd11;
  localparam logic [3:0] S_EM_OUT = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall   = (state != S_LOAD);
  assign result_valid = (state == S_EM_OUT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (item_valid) begin
          cmd.load = 1'b1;
          if (item_last) begin
            cmd.vec_init = 1'b1;
            cmd.rnd_init = 1'b1;
            state_next   = S_CL_RD;
          end
        end
      end
      S_CL_RD: state_next = S_CL_EX;
      S_CL_EX: begin
        cmd.clamp = 1'b1;
        if (sts.idx_last) begin
          state_next = S_DIV_GO;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CL_RD;
        end
      end
      S_DIV_GO: begin
        // skip scaling when nothing is free
        if (sts.free_zero) begin
          state_next = S_RND;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_SC_RD;
        end
      end
      S_SC_RD: state_next = S_SC_CHK;
      S_SC_CHK: begin
        if (!sts.elem_pinned) begin
          cmd.mul_start = 1'b1;
          state_next    = S_SC_MUL;
        end else if (sts.idx_last) begin
          state_next = S_RND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_SC_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          state_next = S_SC_WR;
        end
      end
      S_SC_WR: begin
        cmd.scale_wr = 1'b1;
        if (sts.idx_last) begin
          state_next = S_RND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SC_RD;
        end
      end
      S_RND: begin
        cmd.round_end = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        if (sts.go_on) begin
          cmd.rnd_init = 1'b1;
          state_next   = S_CL_RD;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next  = S_EM_RD;
        end
      end
      S_EM_RD: state_next = S_EM_OUT;
      S_EM_OUT: begin
        // hold the beat until taken
        if (!result_stall) begin
          if (sts.idx_last) begin
            cmd.vec_done = 1'b1;
            state_next   = S_LOAD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_EM_RD;
          end
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/bounded_rate_renormalizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_rate_renormalizer: clamps a rate vector to bounds and rescales it
// Collects up to MAX_VALUES unsigned Q8.24 rates, renormalizes them in
// rounds so the vector sums to one, then streams the corrected vector.
// ----------------------------------------------------------------------------
// Loading accepts one element per cycle. Once the last element is in, each
// round runs a clamp pass with a read and a clamp step per element, tests
// the free sum, then runs the bit-serial scale division and a scale pass
// that reads and checks each element and, for a free element, multiplies
// it in four 16-bit digit steps and writes it back; division and scale pass
// are skipped when no element is free. Each round ends with bookkeeping.
// At most one round more than the number of newly pinned elements runs.
// Output then sends each element in turn. One vector is handled at a time:
// no new element is taken until the last corrected element has left.
// ----------------------------------------------------------------------------
module bounded_rate_renormalizer #(
  parameter int MAX_VALUES = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             item_valid,
  output logic                            item_stall,
  input  brr_pkg::in_beat_t               item,
  output logic                            result_valid,
  input  wire                             result_stall,
  output brr_pkg::out_beat_t              result,
  input  wire                             cfg_we,
  input  wire [brr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [brr_pkg::RATE_W-1:0]       cfg_data
);
  import brr_pkg::*;

  brr_cmd_t cmd;
  brr_sts_t sts;

  brr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (item.last_value),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  brr_datapath #(
    .MAX_VALUES (MAX_VALUES),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result)
  );

  // no input beat is taken while results are being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> item_stall)
    else $error("input taken during output sweep");

  // the last element of a vector starts the rounds
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.last_value) |=> (item_stall && !result_valid))
    else $error("last element did not start processing");

  // the final result beat returns to loading
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.last_out) |=> !item_stall)
    else $error("final beat did not return to load");

endmodule
`default_nettype wire

### tb/sv/brr_scoreboard.sv
// ----------------------------------------------------------------------------
// brr_scoreboard: prediction and checking for the bounded rate renormalizer
// Watches the item, result and register ports. It rebuilds each rate vector,
// runs the clamp-and-rescale rounds on it, and checks every result beat in
// order against the predicted corrected vector.
// ----------------------------------------------------------------------------
module brr_scoreboard (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  input  wire                 item_stall,
  input  brr_pkg::in_beat_t   item,
  input  wire                 result_valid,
  input  wire                 result_stall,
  input  brr_pkg::out_beat_t  result,
  input  wire                 cfg_we,
  input  wire [brr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire [brr_pkg::RATE_W-1:0]      cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import brr_pkg::*;

  localparam int DEPTH = 16;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] WORD_MAX = 64'hFFFF_FFFF;

  logic [63:0] lower_bound, upper_bound;
  logic [63:0] rates [DEPTH];
  int unsigned rate_count;
  out_beat_t   corrected_q [$];

  function automatic logic [63:0] scale_rate(logic [63:0] x, logic [63:0] scale);
    logic [127:0] prod;
    logic [127:0] p;
    prod = x * scale;
    p = prod >> FRAC_BITS;
    return (p > WORD_MAX) ? WORD_MAX : p[63:0];
  endfunction

  // Clamp, pin and rescale until the pin count settles, every free rate sits
  // strictly inside bounds or rounds run out; then queue the corrected vector.
  task automatic renormalize_vector(int unsigned n);
    logic [63:0] lo, hi, mass, scale, free_total, x;
    bit pin_lo [DEPTH];
    bit pin_hi [DEPTH];
    int unsigned prev_pins, now_pins, rounds, nl, nh;
    bit out_of_bounds, no_mass;
    out_beat_t b;
    lo = lower_bound;
    hi = upper_bound;
    prev_pins = 2 * DEPTH + 1;
    now_pins = 0;
    rounds = 0;
    out_of_bounds = 1;
    no_mass = 0;
    for (int i = 0; i < DEPTH; i++) begin
      pin_lo[i] = 0;
      pin_hi[i] = 0;
    end
    while (prev_pins != now_pins && out_of_bounds && rounds < 2 * DEPTH + 2) begin
      free_total = 0;
      nl = 0;
      nh = 0;
      for (int i = 0; i < n; i++) begin
        x = rates[i];
        if (x <= lo) begin
          x = lo;
          pin_lo[i] = 1;
        end else if (hi <= x) begin
          x = hi;
          pin_hi[i] = 1;
        end else begin
          free_total += x;
        end
        rates[i] = x;
      end
      for (int i = 0; i < n; i++) begin
        nl += pin_lo[i];
        nh += pin_hi[i];
      end
      mass = lo * nl + hi * nh;
      out_of_bounds = 0;
      if (free_total != 0) begin
        if (mass >= ONE_Q) begin
          scale = 0;
          no_mass = 1;
        end else begin
          scale = ((ONE_Q - mass) << FRAC_BITS) / free_total;
        end
        for (int i = 0; i < n; i++) begin
          if (!(pin_lo[i] || pin_hi[i])) begin
            x = scale_rate(rates[i], scale);
            rates[i] = x;
            if (x <= lo || hi <= x) out_of_bounds = 1;
          end
        end
      end
      prev_pins = now_pins;
      now_pins = nl + nh;
      rounds++;
    end
    for (int k = 0; k < n; k++) begin
      b.corrected_value = rates[k][31:0];
      b.last_out = (k + 1 == n);
      b.infeasible = no_mass;
      corrected_q.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    int errs;
    errs = 0;
    if (rst) begin
      lower_bound <= MIN_RATE_RST;
      upper_bound <= MAX_RATE_RST;
      rate_count = 0;
      corrected_q.delete();
      fail_count <= 0;
      checked <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MIN_RATE) lower_bound <= cfg_data;
        else if (cfg_index == REG_MAX_RATE) upper_bound <= cfg_data;
      end
      if (item_valid && !item_stall) begin
        // drop rates beyond capacity, but a dropped last beat still ends it
        if (rate_count < DEPTH) begin
          rates[rate_count] = item.rate_value;
          rate_count++;
        end
        if (item.last_value) begin
          renormalize_vector(rate_count);
          rate_count = 0;
        end
      end
      if (result_valid && !result_stall) begin
        checked <= checked + 1;
        if (corrected_q.size() == 0) begin
          $display("%0t: result beat expected none actual %h", $time, result);
          errs++;
        end else begin
          want = corrected_q.pop_front();
          if (want.corrected_value !== result.corrected_value) begin
            $display("%0t: corrected_value expected %h actual %h", $time,
                     want.corrected_value, result.corrected_value);
            errs++;
          end
          if (want.last_out !== result.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time,
                     want.last_out, result.last_out);
            errs++;
          end
          if (want.infeasible !== result.infeasible) begin
            $display("%0t: infeasible expected %b actual %b", $time,
                     want.infeasible, result.infeasible);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
    end
    pending <= corrected_q.size();
  end

endmodule

### tb/sv/bounded_rate_renormalizer_tb.sv
// ----------------------------------------------------------------------------
// bounded_rate_renormalizer_tb: stimulus and verdict
// Drives rate vectors under several bound settings, directed corner vectors
// first and random ones after, with bursty input and a patterned output
// stall; the scoreboard predicts and checks every corrected beat.
// ----------------------------------------------------------------------------
module bounded_rate_renormalizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brr_pkg::*;

  localparam int IDLE_LIMIT = 40000;
  localparam logic [31:0] ONE = 32'h0100_0000;

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_stall;
  in_beat_t item = '0;
  logic result_valid;
  logic result_stall = 0;
  out_beat_t result;
  logic cfg_we = 0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_MIN_RATE;
  logic [RATE_W-1:0] cfg_data = '0;
  int fail_count, pending, checked;
  int burst_left = 0;
  int items_sent = 0;
  int vectors_sent = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  bounded_rate_renormalizer dut (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result,
    .cfg_we, .cfg_index, .cfg_data
  );

  brr_scoreboard scoreboard (
    .clk, .rst, .item_valid, .item_stall, .item,
    .result_valid, .result_stall, .result,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending, .checked
  );

  // output stall: switch among free, light and heavy stalling now and then
  int stall_mode = 0;
  int stall_span = 0;
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(20, 120);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: begin
        result_stall <= 1'b0;
      end
      1: begin
        result_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        result_stall <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_beat(logic [31:0] rate, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    item <= '{rate_value: rate, last_value: last};
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic end_vector;
    vectors_sent++;
  endtask

  task automatic wait_drained;
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_bounds(logic [31:0] lo, logic [31:0] hi);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= REG_MIN_RATE;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_MAX_RATE;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_vector3(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    send_beat(a, 1'b0);
    send_beat(b, 1'b0);
    send_beat(c, 1'b1);
    end_vector();
  endtask

  function automatic logic [31:0] random_rate(int unsigned n);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 64);
      2: return ONE + $urandom_range(0, 32'h0800_0000);
      default: return (ONE / n) + $urandom_range(0, ONE / n) - (ONE / (2 * n));
    endcase
  endfunction

  task automatic random_vectors(int budget);
    int n, target;
    target = items_sent + budget;
    while (items_sent < target) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 16);
      if (n > target - items_sent) n = target - items_sent;
      for (int i = 0; i < n; i++) send_beat(random_rate(n), i == n - 1);
      end_vector();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset bounds, corner values, single element
    send_vector3(32'h0, 32'hFFFF_FFFF, 32'h0040_0000);
    send_beat(32'h0080_0000, 1'b1);
    end_vector();
    // overlong vector: the extra beats are dropped
    for (int i = 0; i < 18; i++) send_beat(32'h0010_0000 + i, i == 17);
    end_vector();

    // no mass left for the free rates
    set_bounds(32'h0080_0000, 32'hFFFF_FFFF);
    send_vector3(32'h0, 32'h0, 32'h0300_0000);
    // nothing free at all
    set_bounds(32'hFFFF_FFFF, 32'h0);
    send_vector3(32'h1234_5678, 32'h0, 32'hFFFF_FFFF);
    // max not above min: every rate pins to a bound
    set_bounds(32'h0040_0000, 32'h0040_0000);
    send_vector3(32'h0040_0000, 32'h0020_0000, 32'h0060_0000);

    set_bounds(MIN_RATE_RST, MAX_RATE_RST);
    random_vectors(22);
    // hold off until everything is out
    wait_drained();
    random_vectors(8);
    set_bounds(32'h0008_0000, 32'h0060_0000);
    random_vectors(22);
    set_bounds(32'h0, 32'hFFFF_FFFF);
    random_vectors(10);
    set_bounds(32'hFFFF_FFFF, 32'h0);
    random_vectors(6);
    set_bounds(32'h0000_0100, 32'h0100_0000);
    random_vectors(11);

    wait_drained();
    $display("Sent %0d rate beats in %0d vectors over seven bound settings,", items_sent,
             vectors_sent);
    $display("checked %0d corrected beats.", checked);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
